@@ hw/rtl/qsb_pkg.sv @@
package qsb_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] FILTER_NONE = 8'h00;
  localparam logic [7:0] FILTER_UP   = 8'h02;
  localparam logic [7:0] BYTE_WHITE  = 8'hff;
  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam logic [3:0] NIB_WHITE   = 4'hf;
  localparam logic [3:0] NIB_DARK    = 4'h0;
  localparam logic [7:0] MARGIN_RUN  = 8'd2;
  localparam logic [7:0] SIDE_RESET  = 8'd21;
  localparam logic [7:0] MARGIN_PAD  = 8'd4;

  localparam logic [4:0] LINE_LAST  = 5'd31;
  localparam logic [4:0] UP_LAST    = 5'd5;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_MODULE = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PH_LINE,
    PH_HEAD0,
    PH_HEAD1,
    PH_DATA,
    PH_TAIL,
    PH_UP
  } phase_t;

  typedef struct packed {
    cmd_t       kind;
    logic       row_start;
    logic       data_valid;
    logic       row_end;
    logic [7:0] data_byte;
    logic [7:0] len;
  } job_t;

endpackage

@@ hw/rtl/qsb_front.sv @@
module qsb_front
  import qsb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic [7:0] cfg_write_data,
  input  logic       accept,
  input  logic [1:0] command,
  input  logic       module_dark,
  output logic       push,
  output job_t       job
);

  logic [7:0] side_modules;
  logic [7:0] column_index;
  logic [7:0] column_index_next;
  logic [3:0] held_nibble;
  logic [3:0] held_nibble_next;
  logic [3:0] nib;
  logic       odd;
  logic       row_end;
  logic [8:0] len_wide;
  cmd_t       cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_modules <= SIDE_RESET;
      column_index <= '0;
      held_nibble  <= NIB_WHITE;
    end else begin
      if (cfg_write_en) begin
        side_modules <= cfg_write_data;
      end
      if (accept) begin
        column_index <= column_index_next;
        held_nibble  <= held_nibble_next;
      end
    end
  end

  always_comb begin
    cmd      = cmd_t'(command);
    nib      = module_dark ? NIB_DARK : NIB_WHITE;
    odd      = column_index[0];
    row_end  = ({1'b0, column_index} + 9'd1) >= {1'b0, side_modules};
    len_wide = (({1'b0, side_modules} + 9'd1) >> 1) + {1'b0, MARGIN_PAD};

    job.kind       = cmd;
    job.row_start  = (column_index == '0);
    job.data_valid = odd || row_end;
    job.row_end    = row_end;
    job.data_byte  = odd ? {held_nibble, nib} : {nib, NIB_WHITE};
    job.len        = len_wide[7:0];

    column_index_next = column_index;
    held_nibble_next  = held_nibble;
    push              = 1'b0;
    case (cmd)
      CMD_START, CMD_FINISH: begin
        column_index_next = '0;
        held_nibble_next  = NIB_WHITE;
        push              = accept;
      end
      CMD_MODULE: begin
        held_nibble_next  = (odd || row_end) ? NIB_WHITE : nib;
        column_index_next = row_end ? '0 : column_index + 8'd1;
        push              = accept && (job.row_start || job.data_valid);
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

endmodule

@@ hw/rtl/qsb_fifo.sv @@
module qsb_fifo
  import qsb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output job_t pop_job
);

  job_t                 entries [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueueCntW-1:0] count;

  assign full      = (count == QueueCntW'(QueueDepth));
  assign pop_valid = (count != '0);
  assign pop_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && pop_valid) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push && !full, pop && pop_valid})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/qsb_back.sv @@
module qsb_back
  import qsb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  job_t       q_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] byte_value,
  output logic [7:0] repeat_count,
  output logic       last
);

  logic       busy;
  logic       busy_next;
  phase_t     phase;
  phase_t     phase_next;
  logic [4:0] cnt;
  logic [4:0] cnt_next;
  job_t       job;
  job_t       job_next;
  logic       out_valid_next;

  logic       adv;
  logic [7:0] run_value;
  logic [7:0] run_count;
  logic       run_done;
  phase_t     run_phase;
  logic [4:0] run_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      phase     <= PH_LINE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      busy      <= busy_next;
      phase     <= phase_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    job <= job_next;
    if (adv) begin
      byte_value   <= run_value;
      repeat_count <= run_count;
      last         <= run_done;
    end
  end

  always_comb begin
    run_value = BYTE_WHITE;
    run_count = 8'd1;
    run_done  = 1'b0;
    run_phase = phase;
    run_cnt   = cnt + 5'd1;
    case (phase)
      PH_LINE: begin
        if (!cnt[0]) begin
          run_value = (job.kind == CMD_START && cnt != '0) ? FILTER_UP : FILTER_NONE;
          run_count = 8'd1;
        end else begin
          run_value = (job.kind == CMD_START && cnt != 5'd1) ? BYTE_ZERO : BYTE_WHITE;
          run_count = job.len;
        end
        run_done = (cnt == LINE_LAST);
      end
      PH_HEAD0: begin
        run_value = FILTER_NONE;
        run_phase = PH_HEAD1;
      end
      PH_HEAD1: begin
        run_value = BYTE_WHITE;
        run_count = MARGIN_RUN;
        run_done  = !job.data_valid;
        run_phase = PH_DATA;
      end
      PH_DATA: begin
        run_value = job.data_byte;
        run_done  = !job.row_end;
        run_phase = PH_TAIL;
      end
      PH_TAIL: begin
        run_value = BYTE_WHITE;
        run_count = MARGIN_RUN;
        run_phase = PH_UP;
        run_cnt   = '0;
      end
      PH_UP: begin
        if (!cnt[0]) begin
          run_value = FILTER_UP;
          run_count = 8'd1;
        end else begin
          run_value = BYTE_ZERO;
          run_count = job.len;
        end
        run_done = (cnt == UP_LAST);
      end
      default: begin
        run_done = 1'b1;
      end
    endcase

    adv = busy && (!out_valid || out_ready);
    pop = q_valid && (!busy || (adv && run_done));

    busy_next  = busy;
    phase_next = phase;
    cnt_next   = cnt;
    job_next   = job;
    if (adv) begin
      phase_next = run_phase;
      cnt_next   = run_cnt;
      if (run_done) begin
        busy_next = 1'b0;
      end
    end
    if (pop) begin
      busy_next = 1'b1;
      job_next  = q_job;
      cnt_next  = '0;
      if (q_job.kind == CMD_MODULE) begin
        phase_next = q_job.row_start ? PH_HEAD0 : PH_DATA;
      end else begin
        phase_next = PH_LINE;
      end
    end

    out_valid_next = adv ? 1'b1 : (out_ready ? 1'b0 : out_valid);
  end

endmodule

@@ hw/rtl/qr_module_png_scanline_builder.sv @@
// QR module to PNG scanline run builder.
// Input channel (in_valid/in_ready): one request per command. START gives the
// 16 top margin lines, MODULE gives one QR module in row order, FINISH gives
// the 16 bottom margin lines. Output channel (out_valid/out_ready): one
// (byte_value, repeat_count) run per transfer; last marks the final run of a
// request. Scanlines are a filter byte plus ceil(side/2)+4 bytes, scaled 4x.
// cfg_write_en/cfg_write_data set side_modules (reset 21); the user must
// write it only while idle; the block does not enforce it. A request is taken
// whenever the 4-entry job queue has room, and its job reaches the back end's
// job register once the back end is free. The run expander sends one run per
// cycle unless out_ready stalls it; a request gives 32 runs for START/FINISH,
// up to 10 at a row end, 1 for most modules, 0 for a held even column (2 at a
// row start). Modules stream at one per cycle until row-end bursts fill the
// queue. Reset clears the queue, the run expander and the column state.
// When the receiver stalls, the current run holds on the output register,
// the expander pauses, and in_ready drops once the queue is full.
module qr_module_png_scanline_builder
  import qsb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic [7:0] cfg_write_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] command,
  input  logic       module_dark,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] byte_value,
  output logic [7:0] repeat_count,
  output logic       last
);

  logic q_full;
  logic q_push;
  job_t q_push_job;
  logic q_pop;
  logic q_valid;
  job_t q_job;

  assign in_ready = !q_full;

  qsb_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .accept         (in_valid && in_ready),
    .command        (command),
    .module_dark    (module_dark),
    .push           (q_push),
    .job            (q_push_job)
  );

  qsb_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (q_push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_job   (q_job)
  );

  qsb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_job        (q_job),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .byte_value   (byte_value),
    .repeat_count (repeat_count),
    .last         (last)
  );

endmodule

@@ hw/rtl/qsb_checker.sv @@
module qsb_checker
  import qsb_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] byte_value,
  input logic [7:0] repeat_count,
  input logic       last
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_value)
      && $stable(repeat_count) && $stable(last))
    else $error("stalled run changed");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> repeat_count != 8'd0 && repeat_count <= 8'd132)
    else $error("repeat count out of range");

  a_long_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && repeat_count > MARGIN_RUN |->
      byte_value == BYTE_ZERO || byte_value == BYTE_WHITE)
    else $error("long run carries pixel data");

endmodule

bind qr_module_png_scanline_builder qsb_checker u_qsb_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .byte_value     (byte_value),
  .repeat_count   (repeat_count),
  .last           (last)
);

@@ sim/scanline_checker.sv @@
`timescale 1ns / 100ps

module scanline_checker
  import qsb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic [7:0] cfg_write_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] command,
  input  logic       module_dark,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] byte_value,
  input  logic [7:0] repeat_count,
  input  logic       last,
  output int         fail_count,
  output int         runs_waiting
);

  localparam int TopLines   = 16;
  localparam int ScaleLines = 4;
  localparam int ReportMax  = 10;

  typedef struct packed {
    logic [7:0] value;
    logic [7:0] count;
    logic       last;
  } run_t;

  run_t       expected_runs[$];
  logic [7:0] side_modules;
  logic [7:0] column_index;
  logic [3:0] held_nibble;

  function automatic void add_run(input logic [7:0] value, input logic [7:0] count);
    run_t r;
    r.value = value;
    r.count = count;
    r.last  = 1'b0;
    expected_runs.push_back(r);
  endfunction

  task automatic predict_runs(input cmd_t cmd, input logic dark);
    int         first_run;
    logic [7:0] line_len;
    logic [3:0] nib;
    first_run = expected_runs.size();
    line_len  = 8'((int'(side_modules) + 1) / 2 + int'(MARGIN_PAD));
    nib       = dark ? NIB_DARK : NIB_WHITE;
    case (cmd)
      CMD_START: begin
        add_run(FILTER_NONE, 8'd1);
        add_run(BYTE_WHITE, line_len);
        for (int k = 1; k < TopLines; k++) begin
          add_run(FILTER_UP, 8'd1);
          add_run(BYTE_ZERO, line_len);
        end
        column_index = '0;
        held_nibble  = NIB_WHITE;
      end
      CMD_MODULE: begin
        if (column_index == 8'd0) begin
          add_run(FILTER_NONE, 8'd1);
          add_run(BYTE_WHITE, MARGIN_RUN);
        end
        if (!column_index[0]) begin
          held_nibble = nib;
        end else begin
          add_run({held_nibble, nib}, 8'd1);
          held_nibble = NIB_WHITE;
        end
        if ({1'b0, column_index} + 9'd1 >= {1'b0, side_modules}) begin
          if (!column_index[0]) add_run({held_nibble, NIB_WHITE}, 8'd1);
          held_nibble = NIB_WHITE;
          add_run(BYTE_WHITE, MARGIN_RUN);
          for (int k = 1; k < ScaleLines; k++) begin
            add_run(FILTER_UP, 8'd1);
            add_run(BYTE_ZERO, line_len);
          end
          column_index = '0;
        end else begin
          column_index = column_index + 8'd1;
        end
      end
      CMD_FINISH: begin
        for (int k = 0; k < TopLines; k++) begin
          add_run(FILTER_NONE, 8'd1);
          add_run(BYTE_WHITE, line_len);
        end
        column_index = '0;
        held_nibble  = NIB_WHITE;
      end
      default: ;
    endcase
    if (expected_runs.size() > first_run)
      expected_runs[expected_runs.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    run_t want;
    if (rst) begin
      expected_runs.delete();
      side_modules = SIDE_RESET;
      column_index = '0;
      held_nibble  = NIB_WHITE;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_runs.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportMax)
            $display("%0t: unexpected run value %0h count %0d last %0b", $time,
                     byte_value, repeat_count, last);
        end else begin
          want = expected_runs.pop_front();
          if (want.value !== byte_value || want.count !== repeat_count ||
              want.last !== last) begin
            fail_count++;
            if (fail_count <= ReportMax)
              $display({"%0t: run mismatch: expected value %0h count %0d last %0b,",
                        " got value %0h count %0d last %0b"},
                       $time, want.value, want.count, want.last,
                       byte_value, repeat_count, last);
          end
        end
      end
      if (cfg_write_en) side_modules = cfg_write_data;
      if (in_valid && in_ready) predict_runs(cmd_t'(command), module_dark);
    end
    runs_waiting = expected_runs.size();
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import qsb_pkg::*;

  localparam int PhaseCount   = 9;
  localparam int PhaseItems   = 20;
  localparam int SettleCycles = 8;
  localparam int HoldCycles   = 300;
  localparam logic [7:0] PhaseSide [PhaseCount] = '{
    8'd1, 8'd6, 8'd255, 8'd2, 8'd5, 8'd3, 8'd7, 8'd4, 8'd9
  };

  logic       clk            = 1'b0;
  logic       rst            = 1'b1;
  logic       cfg_write_en   = 1'b0;
  logic [7:0] cfg_write_data = 8'd0;
  logic       in_valid       = 1'b0;
  logic       in_ready;
  logic [1:0] command        = 2'd0;
  logic       module_dark    = 1'b0;
  logic       out_valid;
  logic       out_ready      = 1'b0;
  logic [7:0] byte_value;
  logic [7:0] repeat_count;
  logic       last;

  int fail_count;
  int runs_waiting;
  int tx_gap_pct     = 34;
  int rx_stall_pct   = 64;
  bit hold_off_start = 1'b0;
  bit rx_hold        = 1'b0;

  always #1 clk = ~clk;

  qr_module_png_scanline_builder i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .module_dark   (module_dark),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .byte_value    (byte_value),
    .repeat_count  (repeat_count),
    .last          (last)
  );

  scanline_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .module_dark   (module_dark),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .byte_value    (byte_value),
    .repeat_count  (repeat_count),
    .last          (last),
    .fail_count    (fail_count),
    .runs_waiting  (runs_waiting)
  );

  always @(negedge clk)
    out_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);

  // hold the receiver off so the job queue fills and the input stalls
  initial begin
    wait (hold_off_start);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic send_request(input cmd_t cmd, input logic dark);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    module_dark <= dark;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_side(input logic [7:0] value);
    in_valid <= 1'b0;
    while (runs_waiting != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  function automatic cmd_t pick_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return CMD_MODULE;
    if (r < 86) return CMD_START;
    if (r < 93) return CMD_FINISH;
    return CMD_NONE;
  endfunction

  initial begin
    cmd_t cmd;
    int   counted;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // odd side: held nibble flushed at row end, ignored command, mid-row resize
    write_side(8'd3);
    send_request(CMD_START, 1'b0);
    send_request(CMD_MODULE, 1'b1);
    send_request(CMD_MODULE, 1'b0);
    send_request(CMD_MODULE, 1'b1);
    send_request(CMD_NONE, 1'b1);
    send_request(CMD_MODULE, 1'b0);
    send_request(CMD_MODULE, 1'b1);
    write_side(8'd2);
    send_request(CMD_MODULE, 1'b1);
    send_request(CMD_MODULE, 1'b1);
    send_request(CMD_MODULE, 1'b1);
    send_request(CMD_FINISH, 1'b0);
    // zero side: every module ends its row
    write_side(8'd0);
    send_request(CMD_MODULE, 1'b1);
    send_request(CMD_MODULE, 1'b0);
    write_side(8'd255);
    send_request(CMD_START, 1'b1);
    send_request(CMD_MODULE, 1'b1);
    send_request(CMD_MODULE, 1'b0);
    send_request(CMD_MODULE, 1'b1);
    send_request(CMD_START, 1'b0);
    send_request(CMD_FINISH, 1'b1);

    for (int p = 0; p < PhaseCount; p++) begin
      if (p == 3) begin
        tx_gap_pct   = 64;
        rx_stall_pct = 34;
      end else if (p == 6) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end
      write_side(PhaseSide[p]);
      if (p == 6) hold_off_start = 1'b1;
      counted = 0;
      while (counted < PhaseItems) begin
        cmd = pick_command();
        send_request(cmd, 1'($urandom_range(0, 1)));
        if (cmd != CMD_NONE) counted++;
      end
    end

    in_valid <= 1'b0;
    while (runs_waiting != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ qr_module_png_scanline_builder.f @@
hw/rtl/qsb_pkg.sv
hw/rtl/qsb_front.sv
hw/rtl/qsb_fifo.sv
hw/rtl/qsb_back.sv
hw/rtl/qr_module_png_scanline_builder.sv
hw/rtl/qsb_checker.sv
sim/scanline_checker.sv
sim/testbench.sv
